// ----- design/sfcf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI NOR command framer package
// Command, status and frame-kind codes, flash opcodes and the frame word
// that passes from the decoder to the serializer.
// ----------------------------------------------------------------------------
package sfcf_pkg;

   localparam int MaxWords    = 5;
   localparam int WordIdxW    = 3;
   localparam int PageBytesDef = 256;
   localparam int DevBytesW   = 25;
   localparam logic [DevBytesW-1:0] DevBytesReset = 25'h100_0000;

   localparam logic [7:0] OP_WREN  = 8'h06;
   localparam logic [7:0] OP_WRDI  = 8'h04;
   localparam logic [7:0] OP_RDSR  = 8'h05;
   localparam logic [7:0] OP_RDID  = 8'h9F;
   localparam logic [7:0] OP_READ  = 8'h03;
   localparam logic [7:0] OP_SE    = 8'h20;
   localparam logic [7:0] OP_CE    = 8'hC7;
   localparam logic [7:0] OP_PP    = 8'h02;
   localparam logic [7:0] OP_DUMMY = 8'hA5;

   typedef enum logic [3:0] {
      CMD_WRITE_EN     = 4'd0,
      CMD_WRDI         = 4'd1,
      CMD_READ_STATUS  = 4'd2,
      CMD_READ_ID      = 4'd3,
      CMD_READ_START   = 4'd4,
      CMD_SECTOR_ERASE = 4'd5,
      CMD_CHIP_ERASE   = 4'd6,
      CMD_PROG_START   = 4'd7,
      CMD_PROG_BYTE    = 4'd8,
      CMD_READ_BYTE    = 4'd9
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_FRAME = 2'd1,
      STATUS_RANGE    = 2'd2,
      STATUS_OPEN     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_READ = 2'd1,
      KIND_PROG = 2'd2,
      KIND_STAT = 2'd3
   } kind_type;

   // All words a request produces; word 0 goes out first.
   typedef struct packed {
      logic [MaxWords-1:0][7:0] words;
      logic [MaxWords-1:0]      ends;
      logic [WordIdxW-1:0]      count;
      status_type               status;
   } frame_type;

endpackage

// ----- design/sfcf_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI NOR command framer decoder
// Tracks the open chip-select frame and the page count, checks the request
// and builds the full word list of its frame in one pass.
// ----------------------------------------------------------------------------
module sfcf_decode #(
   parameter int PageBytes = sfcf_pkg::PageBytesDef
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [sfcf_pkg::DevBytesW-1:0] csr_device_bytes,
   input  logic                           req_fire,
   input  logic [3:0]                     req_command,
   input  logic [23:0]                    req_address,
   input  logic [7:0]                     req_data,
   input  logic                           req_close_after,
   output sfcf_pkg::frame_type            frame
);
   import sfcf_pkg::*;

   localparam int CntW = $clog2(PageBytes + 1);

   logic [DevBytesW-1:0] dev_bytes_ff;
   kind_type             kind_ff, kind_in;
   logic [CntW-1:0]      page_cnt_ff, page_cnt_in;
   logic [CntW-1:0]      page_cnt_inc;
   logic                 needs_addr;
   logic                 addr_bad;
   logic [7:0]           a2, a1, a0;

   assign a2 = req_address[23:16];
   assign a1 = req_address[15:8];
   assign a0 = req_address[7:0];
   assign page_cnt_inc = page_cnt_ff + CntW'(1);
   assign needs_addr = (req_command == CMD_READ_START) ||
                       (req_command == CMD_SECTOR_ERASE) ||
                       (req_command == CMD_PROG_START);
   assign addr_bad = {1'b0, req_address} >= dev_bytes_ff;

   always_comb begin
      frame       = '0;
      frame.count = WordIdxW'(1);
      kind_in     = kind_ff;
      page_cnt_in = page_cnt_ff;
      priority if (req_command > CMD_READ_BYTE) begin
         frame.status = STATUS_NO_FRAME;
      end else if (req_command <= CMD_PROG_START && kind_ff != KIND_NONE) begin
         frame.status = STATUS_OPEN;
      end else if (needs_addr && addr_bad) begin
         frame.status = STATUS_RANGE;
      end else begin
         unique case (req_command)
            CMD_WRITE_EN: begin
               frame.words[0] = OP_WREN;
               frame.ends[0]  = 1'b1;
            end
            CMD_WRDI: begin
               frame.words[0] = OP_WRDI;
               frame.ends[0]  = 1'b1;
            end
            CMD_READ_STATUS: begin
               frame.words[0] = OP_RDSR;
               kind_in        = KIND_STAT;
            end
            CMD_READ_ID: begin
               frame.words = {OP_DUMMY, OP_DUMMY, OP_DUMMY, OP_DUMMY, OP_RDID};
               frame.ends[3] = 1'b1;
               frame.count   = WordIdxW'(4);
            end
            CMD_READ_START: begin
               frame.words = {8'h00, a0, a1, a2, OP_READ};
               frame.count = WordIdxW'(4);
               kind_in     = KIND_READ;
            end
            CMD_SECTOR_ERASE: begin
               frame.words   = {a0, a1, a2, OP_SE, OP_WREN};
               frame.ends[0] = 1'b1;
               frame.ends[4] = 1'b1;
               frame.count   = WordIdxW'(5);
            end
            CMD_CHIP_ERASE: begin
               frame.words   = {8'h00, 8'h00, 8'h00, OP_CE, OP_WREN};
               frame.ends[0] = 1'b1;
               frame.ends[1] = 1'b1;
               frame.count   = WordIdxW'(2);
            end
            CMD_PROG_START: begin
               frame.words   = {a0, a1, a2, OP_PP, OP_WREN};
               frame.ends[0] = 1'b1;
               frame.count   = WordIdxW'(5);
               kind_in       = KIND_PROG;
               page_cnt_in   = '0;
            end
            CMD_PROG_BYTE: begin
               if (kind_ff != KIND_PROG) begin
                  frame.status = STATUS_NO_FRAME;
               end else if (req_close_after ||
                            page_cnt_inc >= CntW'(PageBytes)) begin
                  // close on request or when the page is full
                  frame.words[0] = req_data;
                  frame.ends[0]  = 1'b1;
                  kind_in        = KIND_NONE;
                  page_cnt_in    = '0;
               end else begin
                  frame.words[0] = req_data;
                  page_cnt_in    = page_cnt_inc;
               end
            end
            CMD_READ_BYTE: begin
               if (kind_ff != KIND_READ && kind_ff != KIND_STAT) begin
                  frame.status = STATUS_NO_FRAME;
               end else begin
                  frame.words[0] = OP_DUMMY;
                  frame.ends[0]  = req_close_after;
                  if (req_close_after) begin
                     kind_in = KIND_NONE;
                  end
               end
            end
            default: begin
               frame.status = STATUS_NO_FRAME;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_bytes_ff <= DevBytesReset;
         kind_ff      <= KIND_NONE;
         page_cnt_ff  <= '0;
      end else begin
         if (csr_write) begin
            dev_bytes_ff <= csr_device_bytes;
         end
         if (req_fire) begin
            kind_ff     <= kind_in;
            page_cnt_ff <= page_cnt_in;
         end
      end
   end

endmodule

// ----- design/sfcf_burst.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI NOR command framer serializer
// Holds one decoded frame and moves its words, one per cycle while the result
// register is empty or being taken, into the result register.
// ----------------------------------------------------------------------------
module sfcf_burst (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sfcf_pkg::frame_type frame,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_mosi_byte,
   output logic                rsp_frame_end,
   output logic [1:0]          rsp_status,
   output logic                rsp_last
);
   import sfcf_pkg::*;

   frame_type           frame_ff;
   logic [WordIdxW-1:0] idx_ff;
   logic                busy_ff;
   logic                valid_ff;
   logic [7:0]          byte_ff;
   logic                end_ff;
   status_type          status_ff;
   logic                last_ff;
   logic                out_free;
   logic                emit;
   logic                at_last;
   logic                load;

   assign out_free = !valid_ff || rsp_ready;
   assign emit     = busy_ff && out_free;
   assign at_last  = idx_ff == frame_ff.count - WordIdxW'(1);
   assign in_ready = !busy_ff || (emit && at_last);
   assign load     = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (emit && at_last) begin
            busy_ff <= 1'b0;
         end else if (emit) begin
            idx_ff <= idx_ff + WordIdxW'(1);
         end
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= frame;
      end
      if (emit) begin
         byte_ff   <= frame_ff.words[idx_ff];
         end_ff    <= frame_ff.ends[idx_ff];
         status_ff <= frame_ff.status;
         last_ff   <= at_last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_mosi_byte = byte_ff;
   assign rsp_frame_end = end_ff;
   assign rsp_status    = status_ff;
   assign rsp_last      = last_ff;

endmodule

// ----- design/spi_nor_flash_command_framer_core.sv -----
`timescale 1ns / 1ps
// The accepted frame is registered in the serializer, then each word in the result
// register. Throughput: one result word per cycle while rsp_ready does not stall;
// a request yields 1 to 5 words, so one-word requests go 1/cycle.
// Reset (synchronous, active high): no frame open, page count zero,
// device size 16 MiB, result channel empty.
// ----------------------------------------------------------------------------
// SPI NOR flash command framer
// Turns host requests into MOSI byte sequences with chip-select frame marks.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_framer_core #(
   parameter int PageBytes = sfcf_pkg::PageBytesDef
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sfcf_pkg::DevBytesW-1:0] csr_device_bytes,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [3:0]                     req_command,
   input  logic [23:0]                    req_address,
   input  logic [7:0]                     req_data,
   input  logic                           req_close_after,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_mosi_byte,
   output logic                           rsp_frame_end,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_last
);
   import sfcf_pkg::*;

   frame_type frame;
   logic      req_fire;

   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;

   sfcf_decode #(
      .PageBytes(PageBytes)
   ) u_decode (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_valid && csr_ready),
      .csr_device_bytes(csr_device_bytes),
      .req_fire        (req_fire),
      .req_command     (req_command),
      .req_address     (req_address),
      .req_data        (req_data),
      .req_close_after (req_close_after),
      .frame           (frame)
   );

   sfcf_burst u_burst (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .frame        (frame),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_mosi_byte(rsp_mosi_byte),
      .rsp_frame_end(rsp_frame_end),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI NOR command framer testbench
// Drives host requests, device-size writes and random backpressure into the
// framer. Every accepted response word is checked against a local model of
// the frame sequencer: opcodes, address bytes, chip-select release marks,
// error status and the last-word mark.
// ----------------------------------------------------------------------------
module tb_top;
   import sfcf_pkg::*;

   localparam int WatchdogLimit = 4000;
   localparam int HoldOffCycles = 300;
   localparam logic [3:0] CMD_UNUSED_FIRST = 4'hA;
   localparam logic [3:0] CMD_UNUSED_LAST  = 4'hF;

   typedef struct packed {
      logic [7:0] mosi_byte;
      logic       frame_end;
      status_type status;
      logic       last;
   } mosi_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [DevBytesW-1:0] csr_device_bytes = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [3:0]           req_command = '0;
   logic [23:0]          req_address = '0;
   logic [7:0]           req_data = '0;
   logic                 req_close_after = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_mosi_byte;
   logic                 rsp_frame_end;
   logic [1:0]           rsp_status;
   logic                 rsp_last;

   // model state
   kind_type             open_kind = KIND_NONE;
   logic [8:0]           page_count = '0;
   logic [DevBytesW-1:0] dev_bytes = DevBytesReset;
   mosi_word_type        expected_mosi[$];

   int gap_pct = 31;
   int stall_pct = 31;
   int holdoff_left = 0;
   int mismatches = 0;
   int requests_sent = 0;
   int idle_cycles = 0;

   spi_nor_flash_command_framer_core uut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_device_bytes (csr_device_bytes),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_address      (req_address),
      .req_data         (req_data),
      .req_close_after  (req_close_after),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mosi_byte    (rsp_mosi_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   always #10 clock = ~clock;

   function automatic mosi_word_type ok_word(logic [7:0] b, logic e);
      ok_word = '{b, e, STATUS_OK, 1'b0};
   endfunction

   // Expected MOSI words for one accepted request; updates the frame state.
   function automatic void frame_host_request(logic [3:0] cmd, logic [23:0] addr,
                                              logic [7:0] data, logic close);
      mosi_word_type words[$];
      mosi_word_type w;
      status_type st;
      st = STATUS_OK;
      if (cmd > CMD_READ_BYTE)
         st = STATUS_NO_FRAME;
      else if (cmd < CMD_PROG_BYTE && open_kind != KIND_NONE)
         st = STATUS_OPEN;
      else if ((cmd == CMD_READ_START || cmd == CMD_SECTOR_ERASE || cmd == CMD_PROG_START)
               && {1'b0, addr} >= dev_bytes)
         st = STATUS_RANGE;
      else if (cmd == CMD_PROG_BYTE && open_kind != KIND_PROG)
         st = STATUS_NO_FRAME;
      else if (cmd == CMD_READ_BYTE && open_kind != KIND_READ && open_kind != KIND_STAT)
         st = STATUS_NO_FRAME;

      if (st != STATUS_OK) begin
         words.push_back('{8'h00, 1'b0, st, 1'b0});
      end else begin
         case (cmd)
            CMD_WRITE_EN: words.push_back(ok_word(OP_WREN, 1'b1));
            CMD_WRDI: words.push_back(ok_word(OP_WRDI, 1'b1));
            CMD_READ_STATUS: begin
               words.push_back(ok_word(OP_RDSR, 1'b0));
               open_kind = KIND_STAT;
            end
            CMD_READ_ID: begin
               words.push_back(ok_word(OP_RDID, 1'b0));
               words.push_back(ok_word(OP_DUMMY, 1'b0));
               words.push_back(ok_word(OP_DUMMY, 1'b0));
               words.push_back(ok_word(OP_DUMMY, 1'b1));
            end
            CMD_READ_START: begin
               words.push_back(ok_word(OP_READ, 1'b0));
               words.push_back(ok_word(addr[23:16], 1'b0));
               words.push_back(ok_word(addr[15:8], 1'b0));
               words.push_back(ok_word(addr[7:0], 1'b0));
               open_kind = KIND_READ;
            end
            CMD_SECTOR_ERASE: begin
               words.push_back(ok_word(OP_WREN, 1'b1));
               words.push_back(ok_word(OP_SE, 1'b0));
               words.push_back(ok_word(addr[23:16], 1'b0));
               words.push_back(ok_word(addr[15:8], 1'b0));
               words.push_back(ok_word(addr[7:0], 1'b1));
            end
            CMD_CHIP_ERASE: begin
               words.push_back(ok_word(OP_WREN, 1'b1));
               words.push_back(ok_word(OP_CE, 1'b1));
            end
            CMD_PROG_START: begin
               words.push_back(ok_word(OP_WREN, 1'b1));
               words.push_back(ok_word(OP_PP, 1'b0));
               words.push_back(ok_word(addr[23:16], 1'b0));
               words.push_back(ok_word(addr[15:8], 1'b0));
               words.push_back(ok_word(addr[7:0], 1'b0));
               open_kind = KIND_PROG;
               page_count = '0;
            end
            CMD_PROG_BYTE: begin
               page_count = page_count + 9'd1;
               // a full page releases chip select on its own
               if (close || page_count >= PageBytesDef) begin
                  words.push_back(ok_word(data, 1'b1));
                  open_kind = KIND_NONE;
                  page_count = '0;
               end else begin
                  words.push_back(ok_word(data, 1'b0));
               end
            end
            default: begin
               words.push_back(ok_word(OP_DUMMY, close));
               if (close)
                  open_kind = KIND_NONE;
            end
         endcase
      end

      foreach (words[i]) begin
         w = words[i];
         w.last = (i == words.size() - 1);
         expected_mosi.push_back(w);
      end
   endfunction

   // Called and returns at a falling edge; leaves valid high for a following word.
   task automatic send_request(logic [3:0] cmd, logic [23:0] addr, logic [7:0] data,
                               logic close);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_address     <= addr;
      req_data        <= data;
      req_close_after <= close;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      frame_host_request(cmd, addr, data, close);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_mosi.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_device_bytes(logic [DevBytesW-1:0] value);
      wait_drained();
      csr_valid        <= 1'b1;
      csr_device_bytes <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      dev_bytes = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [23:0] pick_address();
      int unsigned r;
      r = $urandom_range(99);
      if (dev_bytes == 0 || r < 10)
         return 24'($urandom);
      if (r < 20)
         return 24'(dev_bytes - 1);
      if (r < 25 && dev_bytes < DevBytesReset)
         return dev_bytes[23:0];
      return 24'($urandom_range(dev_bytes - 1, 0));
   endfunction

   task automatic test_directed_commands();
      send_request(CMD_WRITE_EN, 24'h000000, 8'h00, 1'b0);
      send_request(CMD_WRDI, 24'hFFFFFF, 8'hFF, 1'b1);
      send_request(CMD_READ_ID, 24'h000000, 8'h00, 1'b0);
      send_request(CMD_CHIP_ERASE, 24'h000000, 8'h00, 1'b0);
      send_request(CMD_SECTOR_ERASE, 24'hFFFFFF, 8'h00, 1'b0);
      send_request(CMD_READ_START, 24'h000000, 8'h00, 1'b0);
      send_request(CMD_READ_BYTE, 24'h000000, 8'h00, 1'b0);
      // collision with the open read frame
      send_request(CMD_WRDI, 24'h000000, 8'h00, 1'b0);
      send_request(CMD_READ_BYTE, 24'h000000, 8'h00, 1'b1);
      send_request(CMD_READ_BYTE, 24'h000000, 8'h00, 1'b1);
      send_request(CMD_PROG_BYTE, 24'h000000, 8'hFF, 1'b0);
      send_request(CMD_READ_STATUS, 24'h000000, 8'h00, 1'b0);
      send_request(CMD_PROG_BYTE, 24'h000000, 8'h11, 1'b0);
      send_request(CMD_READ_BYTE, 24'h000000, 8'h00, 1'b1);
      send_request(CMD_PROG_START, 24'h5AC30F, 8'h00, 1'b0);
      send_request(CMD_PROG_BYTE, 24'h000000, 8'h00, 1'b0);
      send_request(CMD_READ_BYTE, 24'h000000, 8'h00, 1'b0);
      send_request(CMD_PROG_START, 24'h000000, 8'h00, 1'b0);
      send_request(CMD_UNUSED_LAST, 24'hFFFFFF, 8'hFF, 1'b1);
      send_request(CMD_PROG_BYTE, 24'h000000, 8'hFF, 1'b1);
      send_request(CMD_UNUSED_FIRST, 24'h000000, 8'h00, 1'b0);
   endtask

   task automatic test_address_range();
      set_device_bytes(25'd1);
      send_request(CMD_READ_START, 24'h000000, 8'h00, 1'b0);
      send_request(CMD_READ_BYTE, 24'h000000, 8'h00, 1'b1);
      send_request(CMD_READ_START, 24'h000001, 8'h00, 1'b0);
      send_request(CMD_SECTOR_ERASE, 24'h000001, 8'h00, 1'b0);
      send_request(CMD_PROG_START, 24'hFFFFFF, 8'h00, 1'b0);
      send_request(CMD_SECTOR_ERASE, 24'h000000, 8'h00, 1'b0);
      // zero size rejects every start address
      set_device_bytes(25'd0);
      send_request(CMD_READ_START, 24'h000000, 8'h00, 1'b0);
      send_request(CMD_PROG_START, 24'h000000, 8'h00, 1'b0);
      send_request(CMD_SECTOR_ERASE, 24'h000000, 8'h00, 1'b0);
      set_device_bytes(25'h080_0000);
      send_request(CMD_READ_START, 24'h7FFFFF, 8'h00, 1'b0);
      send_request(CMD_READ_BYTE, 24'h000000, 8'h00, 1'b1);
      send_request(CMD_PROG_START, 24'h800000, 8'h00, 1'b0);
      set_device_bytes(DevBytesReset);
      send_request(CMD_PROG_START, 24'hFFFFFF, 8'h00, 1'b0);
      send_request(CMD_PROG_BYTE, 24'h000000, 8'hC3, 1'b1);
   endtask

   task automatic test_page_full();
      send_request(CMD_PROG_START, 24'h001000, 8'h00, 1'b0);
      repeat (PageBytesDef) send_request(CMD_PROG_BYTE, 24'($urandom), 8'($urandom), 1'b0);
      // hold until the page has drained, then check the frame is gone
      wait_drained();
      send_request(CMD_PROG_BYTE, 24'h000000, 8'h3C, 1'b0);
   endtask

   task automatic test_output_holdoff();
      wait_drained();
      gap_pct = 0;
      holdoff_left = HoldOffCycles;
      repeat (15) begin
         send_request(CMD_READ_ID, 24'($urandom), 8'($urandom), 1'($urandom));
         send_request(CMD_SECTOR_ERASE, pick_address(), 8'($urandom), 1'($urandom));
      end
      wait_drained();
      gap_pct = 31;
   endtask

   task automatic run_random_phase(int count, logic [DevBytesW-1:0] size, int idle_pct);
      int target;
      int r;
      int k;
      logic [3:0] singles[5];
      singles = '{CMD_WRITE_EN, CMD_WRDI, CMD_READ_ID, CMD_SECTOR_ERASE, CMD_CHIP_ERASE};
      set_device_bytes(size);
      gap_pct = idle_pct;
      stall_pct = idle_pct;
      target = requests_sent + count;
      while (requests_sent < target) begin
         r = $urandom_range(99);
         if (open_kind != KIND_NONE && r < 80) begin
            // close whatever frame a broken sequence left open
            if (open_kind == KIND_PROG)
               send_request(CMD_PROG_BYTE, 24'($urandom), 8'($urandom), 1'b1);
            else
               send_request(CMD_READ_BYTE, 24'($urandom), 8'($urandom), 1'b1);
         end else if (r < 20) begin
            send_request(singles[$urandom_range(4)], pick_address(), 8'($urandom),
                         1'($urandom));
         end else if (r < 45) begin
            if ($urandom_range(1))
               send_request(CMD_READ_STATUS, 24'($urandom), 8'($urandom), 1'($urandom));
            else
               send_request(CMD_READ_START, pick_address(), 8'($urandom), 1'($urandom));
            k = $urandom_range(6, 1);
            for (int i = 0; i < k; i++)
               send_request(CMD_READ_BYTE, 24'($urandom), 8'($urandom),
                            i == k - 1 && $urandom_range(99) < 95);
         end else if (r < 75) begin
            send_request(CMD_PROG_START, pick_address(), 8'($urandom), 1'($urandom));
            k = $urandom_range(8, 1);
            for (int i = 0; i < k; i++)
               send_request(CMD_PROG_BYTE, 24'($urandom), 8'($urandom),
                            i == k - 1 && $urandom_range(99) < 95);
         end else begin
            send_request(4'($urandom_range(15)), 24'($urandom), 8'($urandom),
                         1'($urandom));
         end
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(8, DevBytesReset, 31);
      run_random_phase(22, 25'($urandom_range(32'h100_0000, 1)), 0);
      run_random_phase(8, 25'($urandom_range(4096, 1)), 31);
      run_random_phase(8, 25'd1, 31);
   endtask

   // Receiver: random stalls, plus a long hold-off on request.
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_ready <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      mosi_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_mosi.size() == 0) begin
            $error("unexpected word: mosi_byte %02h status %0d", rsp_mosi_byte, rsp_status);
            mismatches++;
         end else begin
            want = expected_mosi.pop_front();
            if (rsp_mosi_byte !== want.mosi_byte) begin
               $error("mosi_byte: expected %02h, actual %02h", want.mosi_byte, rsp_mosi_byte);
               mismatches++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $error("frame_end: expected %0b, actual %0b", want.frame_end, rsp_frame_end);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_commands();
      test_address_range();
      test_page_full();
      test_output_holdoff();
      test_random_traffic();
      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatches == 0 && expected_mosi.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
